[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared property wrappers for the heap rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[src/ipheap_pkg.sv]
// ----------------------------------------------------------------------------
// ipheap_pkg
// types, constants and codes of the indexed priority heap
// ----------------------------------------------------------------------------
`default_nettype none

package ipheap_pkg;

	localparam int JOB_SLOTS = 64;
	localparam int JOB_W     = 6;
	localparam int HANDLES   = 2 ** JOB_W;
	localparam int POS_W     = $clog2(JOB_SLOTS);
	localparam int CNT_W     = POS_W + 1;
	localparam int PRIO_W    = 8;
	localparam int RUN_W     = 32;
	localparam int KEY_W     = PRIO_W + RUN_W;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [RUN_W-1:0]  run;
	} key_t;

	typedef enum logic {
		OP_PUSH   = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_QUEUED     = 2'd1,
		STAT_NOT_QUEUED = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RM_RD,
		S_RM_KEY,
		S_UP_TEST,
		S_UP_HEAP,
		S_UP_CMP,
		S_DN_TEST,
		S_DN_HA,
		S_DN_KA,
		S_DN_HB,
		S_DN_KB,
		S_DN_CMP,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

[src/indexed_priority_heap_top.sv]
// ----------------------------------------------------------------------------
// indexed_priority_heap_top
// indexed binary heap of job handles with push and remove by handle
// ----------------------------------------------------------------------------
// One item at a time, from the accepting edge to the result item. A push
// climbs the heap level by level until it reaches the root or a compare
// stops it. A remove fetches the last entry and its key, climbs like a push,
// then sinks level by level until it has no child or a compare stops it. A
// remove of the last entry skips both walks, and a rejected item goes straight
// to the result. The pace is set by the single compare unit and the registered
// read of the heap and key memories, one access per step. The result item is
// registered; a new item is taken once it has been sent.
`default_nettype none

module indexed_priority_heap_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // job, priority_req, run_at, zero fill
	input  wire logic        s_axis_tuser,  // operation
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [15:0] m_axis_tdata,  // top_valid, top_job, count, zero fill
	output logic      [1:0]  m_axis_tuser   // status
);

	`include "assert_macros.svh"

	localparam int JOB_W = ipheap_pkg::JOB_W;
	localparam int POS_W = ipheap_pkg::POS_W;
	localparam int CNT_W = ipheap_pkg::CNT_W;

	ipheap_pkg::state_t state_q, state_nx;

	logic [ipheap_pkg::HANDLES-1:0] queued_q;
	logic [CNT_W-1:0]               size_q;
	logic                           out_valid_q;
	ipheap_pkg::status_t            status_q;
	logic [JOB_W-1:0]               top_q;
	ipheap_pkg::op_t                op_q;
	logic [JOB_W-1:0]               j_job_q;
	ipheap_pkg::key_t               j_key_q;
	logic [POS_W-1:0]               pos_q;
	logic [POS_W-1:0]               c_pos_q;
	logic [JOB_W-1:0]               c_job_q;
	ipheap_pkg::key_t               c_key_q;
	logic [JOB_W-1:0]               b_job_q;

	logic                 accept;
	ipheap_pkg::op_t      in_op;
	logic [JOB_W-1:0]     in_job;
	ipheap_pkg::key_t     in_key;
	logic                 push_ok;
	logic [CNT_W-1:0]     kid;
	logic [CNT_W-1:0]     kid2;
	logic [POS_W-1:0]     parent;

	logic                 heap_we;
	logic [POS_W-1:0]     heap_waddr;
	logic [JOB_W-1:0]     heap_wdata;
	logic [POS_W-1:0]     heap_raddr;
	logic [JOB_W-1:0]     heap_rd;
	logic                 pos_we;
	logic [JOB_W-1:0]     pos_waddr;
	logic [POS_W-1:0]     pos_wdata;
	logic [POS_W-1:0]     pos_rd;
	logic                 key_we;
	logic [JOB_W-1:0]     key_raddr;
	ipheap_pkg::key_t     key_rd;

	ipheap_pkg::key_t     cmp_a_key, cmp_b_key;
	logic [JOB_W-1:0]     cmp_a_job, cmp_b_job;
	logic                 prec;

	assign in_op      = ipheap_pkg::op_t'(s_axis_tuser);
	assign in_job     = s_axis_tdata[5:0];
	assign in_key     = {s_axis_tdata[13:6], s_axis_tdata[45:14]};
	assign s_axis_tready = (state_q == ipheap_pkg::S_IDLE) && !out_valid_q;
	assign accept     = s_axis_tvalid && s_axis_tready;
	assign push_ok    = !queued_q[in_job] && (size_q != CNT_W'(ipheap_pkg::JOB_SLOTS));
	assign kid        = {pos_q, 1'b1};
	assign kid2       = kid + CNT_W'(1);
	assign parent     = (pos_q - POS_W'(1)) >> 1;

	ipheap_ram #(.WIDTH(JOB_W), .DEPTH(ipheap_pkg::JOB_SLOTS)) u_heap_ram (
		.clk   (clk),
		.we    (heap_we),
		.waddr (heap_waddr),
		.wdata (heap_wdata),
		.raddr (heap_raddr),
		.rdata (heap_rd)
	);

	ipheap_ram #(.WIDTH(POS_W), .DEPTH(ipheap_pkg::HANDLES)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (pos_waddr),
		.wdata (pos_wdata),
		.raddr (in_job),
		.rdata (pos_rd)
	);

	ipheap_ram #(.WIDTH(ipheap_pkg::KEY_W), .DEPTH(ipheap_pkg::HANDLES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (in_job),
		.wdata (in_key),
		.raddr (key_raddr),
		.rdata (key_rd)
	);

	ipheap_cmp u_cmp (
		.a_key   (cmp_a_key),
		.a_job   (cmp_a_job),
		.b_key   (cmp_b_key),
		.b_job   (cmp_b_job),
		.a_first (prec)
	);

	// compare operand select
	always_comb begin
		cmp_a_key = c_key_q;
		cmp_a_job = c_job_q;
		cmp_b_key = j_key_q;
		cmp_b_job = j_job_q;
		if (state_q == ipheap_pkg::S_UP_CMP) begin
			cmp_a_key = j_key_q;
			cmp_a_job = j_job_q;
			cmp_b_key = key_rd;
			cmp_b_job = c_job_q;
		end else if (state_q == ipheap_pkg::S_DN_KB) begin
			cmp_a_key = key_rd;
			cmp_a_job = b_job_q;
			cmp_b_key = c_key_q;
			cmp_b_job = c_job_q;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ipheap_pkg::S_IDLE: begin
				if (accept) begin
					if (in_op == ipheap_pkg::OP_PUSH) begin
						state_nx = push_ok ? ipheap_pkg::S_UP_TEST : ipheap_pkg::S_IDLE;
					end else begin
						state_nx = queued_q[in_job] ? ipheap_pkg::S_RM_RD : ipheap_pkg::S_IDLE;
					end
				end
			end
			ipheap_pkg::S_RM_RD: begin
				state_nx = (heap_rd == j_job_q) ? ipheap_pkg::S_DONE : ipheap_pkg::S_RM_KEY;
			end
			ipheap_pkg::S_RM_KEY: state_nx = ipheap_pkg::S_UP_TEST;
			ipheap_pkg::S_UP_TEST: begin
				if (pos_q != '0) begin
					state_nx = ipheap_pkg::S_UP_HEAP;
				end else begin
					state_nx = (op_q == ipheap_pkg::OP_PUSH) ? ipheap_pkg::S_DONE
						: ipheap_pkg::S_DN_TEST;
				end
			end
			ipheap_pkg::S_UP_HEAP: state_nx = ipheap_pkg::S_UP_CMP;
			ipheap_pkg::S_UP_CMP: begin
				if (prec) begin
					state_nx = ipheap_pkg::S_UP_TEST;
				end else begin
					state_nx = (op_q == ipheap_pkg::OP_PUSH) ? ipheap_pkg::S_DONE
						: ipheap_pkg::S_DN_TEST;
				end
			end
			ipheap_pkg::S_DN_TEST: begin
				state_nx = (kid >= size_q) ? ipheap_pkg::S_DONE : ipheap_pkg::S_DN_HA;
			end
			ipheap_pkg::S_DN_HA: state_nx = ipheap_pkg::S_DN_KA;
			ipheap_pkg::S_DN_KA: begin
				state_nx = (kid2 < size_q) ? ipheap_pkg::S_DN_HB : ipheap_pkg::S_DN_CMP;
			end
			ipheap_pkg::S_DN_HB: state_nx = ipheap_pkg::S_DN_KB;
			ipheap_pkg::S_DN_KB: state_nx = ipheap_pkg::S_DN_CMP;
			ipheap_pkg::S_DN_CMP: begin
				state_nx = prec ? ipheap_pkg::S_DN_TEST : ipheap_pkg::S_DONE;
			end
			ipheap_pkg::S_DONE: state_nx = ipheap_pkg::S_IDLE;
			default: state_nx = ipheap_pkg::S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		heap_we    = 1'b0;
		heap_waddr = pos_q;
		heap_wdata = j_job_q;
		heap_raddr = POS_W'(size_q - CNT_W'(1));
		pos_we     = 1'b0;
		pos_waddr  = j_job_q;
		pos_wdata  = pos_q;
		key_we     = 1'b0;
		key_raddr  = heap_rd;
		unique case (state_q) inside
			ipheap_pkg::S_IDLE: begin
				key_we = accept && (in_op == ipheap_pkg::OP_PUSH) && push_ok;
			end
			ipheap_pkg::S_UP_TEST: begin
				heap_raddr = parent;
				if (pos_q == '0 && op_q == ipheap_pkg::OP_PUSH) begin
					heap_we = 1'b1;
					pos_we  = 1'b1;
				end
			end
			ipheap_pkg::S_UP_CMP, ipheap_pkg::S_DN_CMP: begin
				if (prec) begin
					heap_we    = 1'b1;
					heap_wdata = c_job_q;
					pos_we     = 1'b1;
					pos_waddr  = c_job_q;
				end else if (state_q == ipheap_pkg::S_DN_CMP || op_q == ipheap_pkg::OP_PUSH) begin
					heap_we = 1'b1;
					pos_we  = 1'b1;
				end
			end
			ipheap_pkg::S_DN_TEST: begin
				heap_raddr = kid[POS_W-1:0];
				if (kid >= size_q) begin
					heap_we = 1'b1;
					pos_we  = 1'b1;
				end
			end
			ipheap_pkg::S_DN_KA: heap_raddr = kid2[POS_W-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ipheap_pkg::S_IDLE;
			queued_q    <= '0;
			size_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				if (in_op == ipheap_pkg::OP_PUSH) begin
					if (push_ok) begin
						queued_q[in_job] <= 1'b1;
						size_q           <= size_q + CNT_W'(1);
					end else begin
						out_valid_q <= 1'b1;
					end
				end else if (queued_q[in_job]) begin
					queued_q[in_job] <= 1'b0;
					size_q           <= size_q - CNT_W'(1);
				end else begin
					out_valid_q <= 1'b1;
				end
			end
			if (state_q == ipheap_pkg::S_DONE) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (heap_we && heap_waddr == '0) begin
			top_q <= heap_wdata;
		end
		case (state_q) inside
			ipheap_pkg::S_IDLE: begin
				if (accept) begin
					op_q    <= in_op;
					j_job_q <= in_job;
					j_key_q <= in_key;
					pos_q   <= size_q[POS_W-1:0];
					if (in_op == ipheap_pkg::OP_PUSH) begin
						status_q <= push_ok ? ipheap_pkg::STAT_OK : ipheap_pkg::STAT_QUEUED;
					end else begin
						status_q <= queued_q[in_job] ? ipheap_pkg::STAT_OK
							: ipheap_pkg::STAT_NOT_QUEUED;
					end
				end
			end
			ipheap_pkg::S_RM_RD: begin
				pos_q   <= pos_rd;
				j_job_q <= heap_rd;
			end
			ipheap_pkg::S_RM_KEY: j_key_q <= key_rd;
			ipheap_pkg::S_UP_TEST: c_pos_q <= parent;
			ipheap_pkg::S_UP_HEAP: c_job_q <= heap_rd;
			ipheap_pkg::S_UP_CMP, ipheap_pkg::S_DN_CMP: begin
				if (prec) begin
					pos_q <= c_pos_q;
				end
			end
			ipheap_pkg::S_DN_HA: begin
				c_job_q <= heap_rd;
				c_pos_q <= kid[POS_W-1:0];
			end
			ipheap_pkg::S_DN_KA: c_key_q <= key_rd;
			ipheap_pkg::S_DN_HB: b_job_q <= heap_rd;
			ipheap_pkg::S_DN_KB: begin
				if (prec) begin
					c_job_q <= b_job_q;
					c_key_q <= key_rd;
					c_pos_q <= kid2[POS_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = {2'b00, size_q, (size_q != '0) ? top_q : JOB_W'(0),
		(size_q != '0)};

	`ASSERT_ALWAYS(a_count_matches, clk, arst_n, $countones(queued_q) == size_q,
		"queued count differs from heap size")
	`ASSERT_ALWAYS(a_size_bound, clk, arst_n, size_q <= CNT_W'(ipheap_pkg::JOB_SLOTS),
		"heap size beyond slots")
	`ASSERT_IMPLY(a_write_in_heap, clk, arst_n, heap_we, CNT_W'(heap_waddr) < size_q,
		"heap write outside live entries")
	`ASSERT_IMPLY(a_result_idle, clk, arst_n, $rose(out_valid_q),
		state_q == ipheap_pkg::S_IDLE, "result raised while sequencer busy")

endmodule

`default_nettype wire

[src/ipheap_ram.sv]
// ----------------------------------------------------------------------------
// ipheap_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ipheap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[src/ipheap_cmp.sv]
// ----------------------------------------------------------------------------
// ipheap_cmp
// shared order compare: higher priority, then earlier run time, then lower job
// ----------------------------------------------------------------------------
`default_nettype none

module ipheap_cmp (
	input  wire ipheap_pkg::key_t               a_key,
	input  wire logic [ipheap_pkg::JOB_W-1:0]   a_job,
	input  wire ipheap_pkg::key_t               b_key,
	input  wire logic [ipheap_pkg::JOB_W-1:0]   b_job,
	output logic                                a_first
);

	localparam int ORD_W = ipheap_pkg::KEY_W + ipheap_pkg::JOB_W;

	logic [ORD_W-1:0] a_ord;
	logic [ORD_W-1:0] b_ord;

	assign a_ord   = {a_key.prio, ~a_key.run, ~a_job};
	assign b_ord   = {b_key.prio, ~b_key.run, ~b_job};
	assign a_first = a_ord > b_ord;

endmodule

`default_nettype wire

[bench/indexed_priority_heap_top_tb.sv]
// ----------------------------------------------------------------------------
// indexed_priority_heap_top_tb
// self-checking bench for the indexed priority heap: a directed table, then
// random push and remove traffic checked against a behavioral heap, with
// random gaps on the input stream and random stalls on the result stream
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module indexed_priority_heap_top_tb;

	localparam int RAND_ITEMS = 630;
	localparam int CYCLE_LIMIT = 500000;

	typedef struct {
		ipheap_pkg::status_t status;
		logic                top_valid;
		logic [5:0]          top_job;
		logic [6:0]          count;
	} heap_res_t;

	typedef struct {
		ipheap_pkg::op_t op;
		logic [5:0]      job;
		logic [7:0]      prio;
		logic [31:0]     run_at;
		bit              typed;
		heap_res_t       res;
	} heap_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	indexed_priority_heap_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// behavioral heap
	logic [5:0]  slot_job [ipheap_pkg::JOB_SLOTS];
	int          job_pos  [ipheap_pkg::HANDLES];
	bit          queued   [ipheap_pkg::HANDLES];
	logic [7:0]  job_prio [ipheap_pkg::HANDLES];
	logic [31:0] job_run  [ipheap_pkg::HANDLES];
	int          heap_cnt;

	heap_res_t   pending_res[$];
	heap_row_t   dir_rows[$];
	int          mismatches;
	int          cycles;
	bit          no_gaps;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic bit served_first(logic [5:0] a, logic [5:0] b);
		if (job_prio[a] != job_prio[b])
			return job_prio[a] > job_prio[b];
		if (job_run[a] != job_run[b])
			return job_run[a] < job_run[b];
		return a < b;
	endfunction

	function automatic void place(int p, logic [5:0] j);
		slot_job[p] = j;
		job_pos[j] = p;
	endfunction

	function automatic int sift_up(int p);
		logic [5:0] j;
		int par;
		j = slot_job[p];
		while (p > 0) begin
			par = (p - 1) / 2;
			if (!served_first(j, slot_job[par]))
				break;
			place(p, slot_job[par]);
			p = par;
		end
		place(p, j);
		return p;
	endfunction

	function automatic void sink_entry(int p);
		logic [5:0] j;
		int kid;
		j = slot_job[p];
		forever begin
			kid = 2 * p + 1;
			if (kid >= heap_cnt)
				break;
			if (kid + 1 < heap_cnt && served_first(slot_job[kid + 1], slot_job[kid]))
				kid++;
			if (!served_first(slot_job[kid], j))
				break;
			place(p, slot_job[kid]);
			p = kid;
		end
		place(p, j);
	endfunction

	function automatic heap_res_t heap_apply(ipheap_pkg::op_t op, logic [5:0] j,
		logic [7:0] pr, logic [31:0] rt);
		heap_res_t r;
		int hole;
		logic [5:0] last;
		r.status = ipheap_pkg::STAT_OK;
		if (op == ipheap_pkg::OP_PUSH) begin
			if (queued[j] || heap_cnt >= ipheap_pkg::JOB_SLOTS) begin
				r.status = ipheap_pkg::STAT_QUEUED;
			end else begin
				job_prio[j] = pr;
				job_run[j] = rt;
				queued[j] = 1'b1;
				heap_cnt++;
				place(heap_cnt - 1, j);
				void'(sift_up(heap_cnt - 1));
			end
		end else begin
			if (!queued[j]) begin
				r.status = ipheap_pkg::STAT_NOT_QUEUED;
			end else begin
				hole = job_pos[j];
				queued[j] = 1'b0;
				last = slot_job[heap_cnt - 1];
				heap_cnt--;
				if (last != j) begin
					place(hole, last);
					sink_entry(sift_up(hole));
				end
			end
		end
		r.top_valid = heap_cnt > 0;
		r.top_job = heap_cnt > 0 ? slot_job[0] : 6'd0;
		r.count = heap_cnt[6:0];
		return r;
	endfunction

	function automatic int gap_len();
		int k;
		if (no_gaps)
			return 0;
		k = $urandom_range(99);
		if (k < 45)
			return 0;
		if (k < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	task automatic add_row(ipheap_pkg::op_t op, logic [5:0] j, logic [7:0] pr,
		logic [31:0] rt, bit typed, ipheap_pkg::status_t st, logic tv, logic [5:0] tj,
		logic [6:0] cnt);
		heap_row_t row;
		row.op = op;
		row.job = j;
		row.prio = pr;
		row.run_at = rt;
		row.typed = typed;
		row.res.status = st;
		row.res.top_valid = tv;
		row.res.top_job = tj;
		row.res.count = cnt;
		dir_rows.insert(dir_rows.size(), row);
	endtask

	task automatic send_item(heap_row_t row);
		heap_res_t r;
		int g;
		g = gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= row.op;
		s_axis_tdata  <= {2'b00, row.run_at, row.prio, row.job};
		do @(posedge clk); while (!s_axis_tready);
		r = heap_apply(row.op, row.job, row.prio, row.run_at);
		pending_res.insert(pending_res.size(), row.typed ? row.res : r);
		@(negedge clk);
	endtask

	function automatic logic [5:0] pick_job(bit want_queued);
		logic [5:0] cands[$];
		for (int i = 0; i < ipheap_pkg::HANDLES; i++)
			if (queued[i] == want_queued)
				cands.insert(cands.size(), i[5:0]);
		if (cands.size() == 0)
			return 6'($urandom_range(63));
		return cands[$urandom_range(cands.size() - 1)];
	endfunction

	// result checking
	always @(posedge clk) begin
		heap_res_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_res.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item: %h / %h", m_axis_tuser, m_axis_tdata);
			end else begin
				e = pending_res.pop_front();
				if (m_axis_tuser !== e.status || m_axis_tdata[0] !== e.top_valid ||
					m_axis_tdata[6:1] !== e.top_job || m_axis_tdata[13:7] !== e.count ||
					m_axis_tdata[15:14] !== 2'b00) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("mismatch: expected st=%0d tv=%0d top=%0d cnt=%0d",
							e.status, e.top_valid, e.top_job, e.count);
						$display(", got st=%0d tv=%0d top=%0d cnt=%0d", m_axis_tuser,
							m_axis_tdata[0], m_axis_tdata[6:1], m_axis_tdata[13:7]);
					end
				end
			end
		end
	end

	// result stalls
	initial begin
		int k;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			k = $urandom_range(99);
			if (no_gaps || k < 55) begin
				m_axis_tready <= 1'b1;
			end else if (k < 95) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(3, 1)) @(negedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(40, 10)) @(negedge clk);
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("indexed_priority_heap_top test failed");
				$finish;
			end
		end
	end

	initial begin
		heap_row_t row;
		int k;
		mismatches = 0;
		no_gaps = 1'b0;
		heap_cnt = 0;
		for (int i = 0; i < ipheap_pkg::HANDLES; i++)
			queued[i] = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = ipheap_pkg::OP_PUSH;
		s_axis_tdata = '0;

		// directed: empty heap, extremes, duplicates, tie-breaks, last entry
		add_row(ipheap_pkg::OP_REMOVE, 6'd5,  8'hFF, 32'hFFFF_FFFF, 1,
			ipheap_pkg::STAT_NOT_QUEUED, 0, 6'd0, 7'd0);
		add_row(ipheap_pkg::OP_PUSH,   6'd0,  8'h00, 32'h0,         1,
			ipheap_pkg::STAT_OK,         1, 6'd0, 7'd1);
		add_row(ipheap_pkg::OP_PUSH,   6'd0,  8'hFF, 32'h0,         1,
			ipheap_pkg::STAT_QUEUED,     1, 6'd0, 7'd1);
		add_row(ipheap_pkg::OP_PUSH,   6'd63, 8'hFF, 32'hFFFF_FFFF, 1,
			ipheap_pkg::STAT_OK,         1, 6'd63, 7'd2);
		add_row(ipheap_pkg::OP_PUSH,   6'd1,  8'hFF, 32'h0,         1,
			ipheap_pkg::STAT_OK,         1, 6'd1, 7'd3);
		add_row(ipheap_pkg::OP_PUSH,   6'd2,  8'hFF, 32'h0,         1,
			ipheap_pkg::STAT_OK,         1, 6'd1, 7'd4);
		add_row(ipheap_pkg::OP_PUSH,   6'd42, 8'h80, 32'h5555_AAAA, 0,
			ipheap_pkg::STAT_OK, 0, 0, 0);
		add_row(ipheap_pkg::OP_PUSH,   6'd21, 8'h7F, 32'hAAAA_5555, 0,
			ipheap_pkg::STAT_OK, 0, 0, 0);
		add_row(ipheap_pkg::OP_REMOVE, 6'd1,  8'h00, 32'h0,         1,
			ipheap_pkg::STAT_OK,         1, 6'd2, 7'd5);
		add_row(ipheap_pkg::OP_REMOVE, 6'd1,  8'h00, 32'h0,         1,
			ipheap_pkg::STAT_NOT_QUEUED, 1, 6'd2, 7'd5);
		add_row(ipheap_pkg::OP_REMOVE, 6'd0,  8'h00, 32'h0,         0,
			ipheap_pkg::STAT_OK, 0, 0, 0);
		add_row(ipheap_pkg::OP_REMOVE, 6'd21, 8'h00, 32'h0,         0,
			ipheap_pkg::STAT_OK, 0, 0, 0);
		add_row(ipheap_pkg::OP_REMOVE, 6'd2,  8'h00, 32'h0,         0,
			ipheap_pkg::STAT_OK, 0, 0, 0);
		add_row(ipheap_pkg::OP_REMOVE, 6'd42, 8'h00, 32'h0,         0,
			ipheap_pkg::STAT_OK, 0, 0, 0);
		add_row(ipheap_pkg::OP_REMOVE, 6'd63, 8'h00, 32'h0,         1,
			ipheap_pkg::STAT_OK,         0, 6'd0, 7'd0);
		add_row(ipheap_pkg::OP_PUSH,   6'd9,  8'h10, 32'h0,         1,
			ipheap_pkg::STAT_OK,         1, 6'd9, 7'd1);
		add_row(ipheap_pkg::OP_REMOVE, 6'd9,  8'h10, 32'h0,         1,
			ipheap_pkg::STAT_OK,         0, 6'd0, 7'd0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i]);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 50 == 0)
				no_gaps = $urandom_range(3) == 0;
			k = $urandom_range(99);
			// drift between filling and draining so the heap reaches full and empty
			if (((n / 100) % 2 == 0) ? k < 88 : k < 12)
				row.op = ipheap_pkg::OP_PUSH;
			else
				row.op = ipheap_pkg::OP_REMOVE;
			if ($urandom_range(9) < 8)
				row.job = pick_job(row.op == ipheap_pkg::OP_REMOVE);
			else
				row.job = 6'($urandom_range(63));
			k = $urandom_range(2);
			row.prio = k == 0 ? 8'($urandom_range(3)) : 8'($urandom_range(255));
			k = $urandom_range(2);
			row.run_at = k == 0 ? $urandom_range(3) : $urandom();
			row.typed = 1'b0;
			send_item(row);
		end
		s_axis_tvalid <= 1'b0;

		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("indexed_priority_heap_top test passed");
		else
			$display("indexed_priority_heap_top test failed");
		$finish;
	end

endmodule

`default_nettype wire
